// File: sv/sdtf_pkg.sv
// Shared types and constants of the signed decimal text formatter.
package sdtf_pkg;

  localparam int unsigned NumDigits = 6;
  localparam int unsigned MagWidth  = 17;

  localparam logic [1:0] ModeByte  = 2'd0;
  localparam logic [1:0] ModeFour  = 2'd1;
  localparam logic [1:0] ModeSix   = 2'd2;
  localparam logic [1:0] ModeSpare = 2'd3;

  // Register index of digit_mode, as seen on paddr[2].
  localparam logic RegIdxDigitMode = 1'b0;

  localparam logic [2:0] NdigByte = 3'd3;
  localparam logic [2:0] NdigFour = 3'd4;
  localparam logic [2:0] NdigSix  = 3'd6;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;

  // floor(x / 10) == (x * DivRecip) >> DivShift for every x below 81920.
  localparam logic [MagWidth-1:0] DivRecip = 17'd52429;
  localparam int unsigned         DivShift = 19;

  typedef struct packed {
    logic [MagWidth-1:0]            rest;
    logic [NumDigits-1:0][3:0]      digits;
    logic [NumDigits-1:0]           blank;
    logic                           neg;
    logic [2:0]                     ndig;
  } rec_t;

endpackage

// File: sv/sdtf_cell.sv
// One digit cell: peels off a decimal digit and hands the quotient to the next cell.
module sdtf_cell import sdtf_pkg::*; #(
  parameter int unsigned DigitIdx = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  rec_t in_rec_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rec_t out_rec_o
);

  logic                      valid_q;
  rec_t                      rec_q, rec_d;
  logic [2*MagWidth-1:0]     prod;
  logic [MagWidth-1:0]       quot;
  logic [MagWidth-1:0]       diff;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_rec_o   = rec_q;

  always_comb begin
    prod = in_rec_i.rest * DivRecip;
    quot = MagWidth'(prod >> DivShift);
    diff = in_rec_i.rest - ((quot << 3) + (quot << 1));
    rec_d = in_rec_i;
    rec_d.rest = quot;
    rec_d.digits[DigitIdx] = diff[3:0];
    // The magnitude is below 10^DigitIdx exactly when nothing is left above it.
    rec_d.blank[DigitIdx] = (in_rec_i.rest == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rec_q <= rec_d;
    end
  end

endmodule

// File: sv/sdtf_serializer.sv
// Output stage: sends the sign and the digits of one field, one character per transaction.
module sdtf_serializer import sdtf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  rec_t       in_rec_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] character_o,
  output logic [2:0] position_o,
  output logic       last_o
);

  logic       valid_q;
  logic [2:0] pos_q;
  rec_t       rec_q;
  logic [2:0] didx;
  logic [2:0] sel;

  assign last_o      = (pos_q == rec_q.ndig);
  assign in_ready_o  = !valid_q || (out_ready_i && last_o);
  assign out_valid_o = valid_q;
  assign position_o  = pos_q;

  always_comb begin
    didx = rec_q.ndig - pos_q;
    sel  = (didx < 3'(NumDigits)) ? didx : 3'd0;
    if (pos_q == 3'd0) begin
      character_o = rec_q.neg ? ChMinus : ChSpace;
    end else if (sel != 3'd0 && rec_q.blank[sel]) begin
      character_o = ChSpace;
    end else begin
      character_o = ChZero + {4'd0, rec_q.digits[sel]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= 3'd0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
      pos_q   <= 3'd0;
    end else if (out_ready_i) begin
      pos_q <= pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rec_q <= in_rec_i;
    end
  end

endmodule

// File: sv/signed_decimal_text_formatter_top.sv
// Top level of the signed decimal text formatter with its register port.
//
// A signed 16-bit value enters on the input channel (in_valid_i / in_ready_o)
// and leaves as a fixed-width text field on the output channel, one ASCII
// character per transaction: the sign, then 3, 4 or 6 digits with leading
// zeros shown as spaces. last_o marks the units digit.
// digit_mode (byte address 0) picks the width: 0 uses the low 8 bits and
// 3 digits, 1 gives 4 digits, 2 and 3 give 6 digits. It resets to 2.
// A row of six registered digit cells takes off one digit per cell, and the
// output stage registers the record before the first character of a field
// is offered. The output stage sends N+1 characters per field, one per cycle
// while out_ready_i is high, and takes the next record with the last one. The
// cells keep taking new values while the output stage drains a field.
// When the receiver stalls, the current character holds and the cells fill
// up behind it; in_ready_o falls once every cell holds a value.
// Reset empties the cells and the output stage and restores digit_mode.
module signed_decimal_text_formatter_top import sdtf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  character_o,
  output logic [2:0]  position_o,
  output logic        last_o
);

  logic [1:0] mode_q;
  rec_t       rec_in;
  logic [8:0] mag_byte;

  rec_t [NumDigits:0] chain_rec;
  logic [NumDigits:0] chain_valid;
  logic [NumDigits:0] chain_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegIdxDigitMode) ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeSix;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegIdxDigitMode) begin
      mode_q <= pwdata[1:0];
    end
  end

  always_comb begin
    mag_byte = 9'h100 - {1'b0, value_i[7:0]};
    rec_in = '0;
    if (mode_q == ModeByte) begin
      rec_in.neg  = value_i[7];
      rec_in.rest = value_i[7] ? {8'd0, mag_byte} : {9'd0, value_i[7:0]};
      rec_in.ndig = NdigByte;
    end else begin
      rec_in.neg  = value_i[15];
      rec_in.rest = value_i[15] ? (17'h10000 - {1'b0, value_i}) : {1'b0, value_i};
      rec_in.ndig = (mode_q == ModeFour) ? NdigFour : NdigSix;
    end
  end

  assign chain_rec[0]   = rec_in;
  assign chain_valid[0] = in_valid_i;
  assign in_ready_o     = chain_ready[0];

  for (genvar k = 0; k < NumDigits; k++) begin : g_cell
    sdtf_cell #(
      .DigitIdx(k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_rec_i    (chain_rec[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_rec_o   (chain_rec[k+1])
    );
  end

  sdtf_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[NumDigits]),
    .in_ready_o  (chain_ready[NumDigits]),
    .in_rec_i    (chain_rec[NumDigits]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .position_o  (position_o),
    .last_o      (last_o)
  );

endmodule

// File: dv/signed_decimal_text_formatter_top_tb.sv
// Self-checking testbench for the signed decimal text formatter in all digit modes.
`timescale 1ns / 100ps

module signed_decimal_text_formatter_top_tb;
  import sdtf_pkg::*;

  localparam logic [2:0] DigitModeAddr = 3'd0;
  localparam logic [2:0] UnmappedAddr  = 3'd4;

  localparam int unsigned ItemsPerPhase = 25;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct {
    logic [7:0] ch;
    logic [2:0] pos;
    logic       last;
  } text_char_t;

  // Predicts the text field of each value and checks the characters in order.
  class text_field_scoreboard;
    logic [1:0]  digit_mode;
    text_char_t  field_q[$];
    int unsigned errors;
    int unsigned values_seen;
    int unsigned chars_checked;

    function new();
      digit_mode    = ModeSix;
      errors        = 0;
      values_seen   = 0;
      chars_checked = 0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
      if (addr == DigitModeAddr) begin
        digit_mode = data[1:0];
      end
    endfunction

    function void note_value(logic [15:0] v);
      int unsigned ndig, mag, rest, scale;
      int unsigned digit [6];
      int          i;
      logic        neg;
      text_char_t  c;
      if (digit_mode == ModeByte) begin
        ndig = 3;
        neg  = v[7];
        mag  = neg ? 256 - v[7:0] : v[7:0];
      end else begin
        ndig = (digit_mode == ModeFour) ? 4 : 6;
        neg  = v[15];
        mag  = neg ? 65536 - v : v;
      end
      rest = mag;
      for (i = 0; i < ndig; i++) begin
        digit[i] = rest % 10;
        rest     = rest / 10;
      end
      c.ch   = neg ? ChMinus : ChSpace;
      c.pos  = 3'd0;
      c.last = 1'b0;
      field_q.push_back(c);
      // The blanking threshold for position k is 10^(ndig-k), taken from the full magnitude.
      scale = 1;
      for (i = 1; i < ndig; i++) begin
        scale = scale * 10;
      end
      for (i = 1; i <= ndig; i++) begin
        c.ch = 8'(ChZero + digit[ndig - i]);
        if (i < ndig && mag < scale) begin
          c.ch = ChSpace;
        end
        c.pos  = 3'(i);
        c.last = (i == ndig);
        field_q.push_back(c);
        scale = scale / 10;
      end
      values_seen++;
    endfunction

    function void check_char(logic [7:0] ch, logic [2:0] pos, logic last);
      text_char_t e;
      if (field_q.size() == 0) begin
        $error("unexpected character %h at position %0d, last %0b", ch, pos, last);
        errors++;
      end else begin
        e = field_q.pop_front();
        chars_checked++;
        if (ch !== e.ch) begin
          $error("character: expected %h, got %h", e.ch, ch);
          errors++;
        end
        if (pos !== e.pos) begin
          $error("position: expected %0d, got %0d", e.pos, pos);
          errors++;
        end
        if (last !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, last);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return field_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  character_o;
  logic [2:0]  position_o;
  logic        last_o;

  text_field_scoreboard sb;
  bit          calm;
  bit          hold_req;
  int unsigned quiet_cycles;

  logic [15:0] six_cases  [11] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h0063, 16'h0064, 16'h03E7,
                                   16'h03E8, 16'h270F, 16'h2710, 16'h7FFF, 16'h8000};
  logic [15:0] byte_cases [5]  = '{16'hA57F, 16'h0080, 16'h12FF, 16'h0064, 16'h3C09};
  logic [15:0] four_cases [4]  = '{16'h270F, 16'h2710, 16'h8000, 16'hFC19};
  logic [1:0]  phase_modes [NumPhases] = '{ModeByte, ModeFour, ModeSix, ModeSpare,
                                           ModeSix, ModeByte, ModeFour, ModeSpare};

  signed_decimal_text_formatter_top uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_value();
    int unsigned pow10 [5] = '{1, 10, 100, 1000, 10000};
    logic [15:0] edges [6] = '{16'h8000, 16'h7FFF, 16'h0080, 16'h007F, 16'hFF80, 16'hFF81};
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: begin
        v = 16'($urandom);
      end
      1: begin
        v = 16'($urandom_range(0, 300));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      2: begin
        v = 16'(pow10[$urandom_range(0, 4)] + $urandom_range(0, 4) - 2);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        v = edges[$urandom_range(0, 5)];
      end
    endcase
    return v;
  endfunction

  // Holds valid and the value until the block takes the transaction.
  task automatic send_value(input logic [15:0] v);
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_value(v);
  endtask

  task automatic send_item(input logic [15:0] v);
    int unsigned gap;
    send_value(v);
    gap = calm ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    write_reg(DigitModeAddr, {$urandom_range(0, 1) ? 30'h2AAA_5555 : 30'h0, mode});
  endtask

  // Result side: random stalls, a free-running stretch, and one long hold-off on request.
  initial begin
    int unsigned n;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        n = idle_cycles();
        if (n == 0) begin
          out_ready_i <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end else begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null && out_valid_o && out_ready_i) begin
      sb.check_char(character_o, position_o, last_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("No transaction for %0d cycles, stopping.", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    sb           = new();
    calm         = 1'b0;
    hold_req     = 1'b0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    value_i      = '0;
    out_ready_i  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the reset mode first, then the byte and four-digit modes.
    foreach (six_cases[i]) send_item(six_cases[i]);
    wait_drained();
    set_mode(ModeByte);
    foreach (byte_cases[i]) send_item(byte_cases[i]);
    wait_drained();
    set_mode(ModeFour);
    foreach (four_cases[i]) send_item(four_cases[i]);
    wait_drained();
    // The spare mode code must behave like six digits, and a write outside
    // the register map must leave the mode alone.
    set_mode(ModeSpare);
    send_item(16'h0000);
    send_item(16'h8000);
    wait_drained();
    write_reg(UnmappedAddr, {30'h0, ModeByte});
    send_item(16'h3039);

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      set_mode(phase_modes[p]);
      calm = (p == 2);
      if (p == 5) begin
        hold_req = 1'b1;
      end
      repeat (ItemsPerPhase) begin
        if (p == 5) begin
          send_value(pick_value());
        end else begin
          send_item(pick_value());
        end
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Formatted %0d values into %0d checked characters over all four mode codes,",
             sb.values_seen, sb.chars_checked);
    $display("with random stalls on both channels and one long result-side hold-off.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
